// File: rtl/core/i2c_seq_pkg.sv
package i2c_seq_pkg;

    // Controller events and host commands, carried in s_tuser
    typedef enum logic [2:0] {
        CMD_LOAD          = 3'd0,
        CMD_BEGIN         = 3'd1,
        CMD_START_SENT    = 3'd2,
        CMD_ADDR_SENT     = 3'd3,
        CMD_BYTE_RECEIVED = 3'd4,
        CMD_TX_EMPTY      = 3'd5
    } cmd_t;

    // ACK control codes in the result
    typedef enum logic [1:0] {
        ACK_NONE    = 2'd0,
        ACK_ENABLE  = 2'd1,
        ACK_DISABLE = 2'd2
    } ack_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_DEVICE_ADDRESS = 2'd0,
        REG_WRITE_LENGTH   = 2'd1,
        REG_READ_LENGTH    = 2'd2,
        REG_TRANSFER_MODE  = 2'd3
    } cfg_reg_t;

    localparam int CFG_DATA_WIDTH = 8;
    localparam int INDEX_WIDTH    = 5;
    localparam logic [INDEX_WIDTH-1:0] INDEX_MAX = 5'd31;

    localparam int S_TDATA_WIDTH = 24;
    localparam int M_TDATA_WIDTH = 32;

    // One result item; tx_from_ram selects the buffer read data for tx_byte
    typedef struct packed {
        logic       tx_valid;
        logic       tx_from_ram;
        logic [7:0] tx_byte;
        ack_t       ack_ctrl;
        logic       stop_req;
        logic       start_req;
        logic       rx_valid;
        logic [3:0] rx_index;
        logic [7:0] rx_data;
    } result_t;

endpackage

// File: rtl/core/i2c_seq_ram.sv
module i2c_seq_ram #(
    parameter int WIDTH      = 8,
    parameter int DEPTH      = 16,
    parameter int ADDR_WIDTH = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [ADDR_WIDTH-1:0] wr_addr,
    input  logic [WIDTH-1:0]      wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_WIDTH-1:0] rd_addr,
    output logic [WIDTH-1:0]      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/core/i2c_master_transfer_sequencer_top.sv
// Channel  Direction  Transfer contents
// -------  ---------  --------------------------------------------------------
// s_*      in         one controller event or host command (cmd in tuser)
// m_*      out        one result: tx byte, ACK change, stop/start, rx store
// cfg_*    in         register write: device address, lengths, transfer mode
//
// Every event gives exactly one result; one event is taken each cycle unless
// m_tready holds the result back. An event passes an input register, then the
// result register, with the buffer RAM read registered alongside the result.
// The input register lets a new event in while a result waits on m_tready.
// rst_n clears the phase, byte index, configuration and pipeline valids; the
// data buffer is not cleared and must be loaded before it is sent.
module i2c_master_transfer_sequencer_top #(
    parameter int BUFFER_DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [3:0] load_index, [11:4] load_byte, [19:12] rx_byte, [23:20] zero
    input  logic [i2c_seq_pkg::S_TDATA_WIDTH-1:0] s_tdata,
    // [2:0] cmd
    input  logic [2:0]                           s_tuser,

    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [0] tx_valid, [8:1] tx_byte, [10:9] ack_ctrl, [11] stop_req,
    // [12] start_req, [13] rx_valid, [17:14] rx_index, [25:18] rx_data,
    // [31:26] zero
    output logic [i2c_seq_pkg::M_TDATA_WIDTH-1:0] m_tdata,

    input  logic                                 cfg_we,
    input  i2c_seq_pkg::cfg_reg_t                cfg_index,
    input  logic [i2c_seq_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);

    import i2c_seq_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);

    // Configuration registers
    logic [7:0]             device_address_reg;
    logic [INDEX_WIDTH-1:0] write_length_reg;
    logic [INDEX_WIDTH-1:0] read_length_reg;
    logic                   transfer_mode_reg;

    // Sequencer state
    logic                   read_phase_reg;
    logic                   read_phase_next;
    logic [INDEX_WIDTH-1:0] byte_index_reg;
    logic [INDEX_WIDTH-1:0] byte_index_next;
    logic [INDEX_WIDTH-1:0] index_step;

    // Input stage
    logic       a_valid_reg;
    cmd_t       a_cmd_reg;
    logic [3:0] a_load_index_reg;
    logic [7:0] a_load_byte_reg;
    logic [7:0] a_rx_byte_reg;
    logic       a_move;
    logic       s_accept;

    // Result stage
    logic    b_valid_reg;
    result_t b_res_reg;
    result_t b_res_next;

    // Buffer RAM
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [7:0]    ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [7:0]    ram_rd_data;

    logic [7:0] tx_byte_out;
    logic       index_in_range;

    // Handshake: input moves when the result stage is free or draining
    assign a_move   = a_valid_reg && (!b_valid_reg || m_tready);
    assign s_tready = !a_valid_reg || a_move;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = b_valid_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg <= '0;
            write_length_reg   <= '0;
            read_length_reg    <= '0;
            transfer_mode_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEVICE_ADDRESS: device_address_reg <= cfg_data;
                REG_WRITE_LENGTH:   write_length_reg   <= cfg_data[INDEX_WIDTH-1:0];
                REG_READ_LENGTH:    read_length_reg    <= cfg_data[INDEX_WIDTH-1:0];
                REG_TRANSFER_MODE:  transfer_mode_reg  <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // Input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (a_move)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            a_cmd_reg        <= cmd_t'(s_tuser);
            a_load_index_reg <= s_tdata[3:0];
            a_load_byte_reg  <= s_tdata[11:4];
            a_rx_byte_reg    <= s_tdata[19:12];
        end
    end

    // Saturating byte index advance
    assign index_step     = (byte_index_reg < INDEX_MAX) ? byte_index_reg + 5'd1
                                                         : byte_index_reg;
    assign index_in_range = (32'(byte_index_reg) < BUFFER_DEPTH);

    // Decode the event in the input register into state, RAM access and result
    always_comb
    begin
        b_res_next      = '0;
        read_phase_next = read_phase_reg;
        byte_index_next = byte_index_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = AW'(byte_index_reg);
        ram_wr_data     = a_rx_byte_reg;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = AW'(byte_index_reg);

        if (a_move)
        begin
            unique case (a_cmd_reg)
                CMD_LOAD:
                begin
                    if (32'(a_load_index_reg) < BUFFER_DEPTH)
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = AW'(a_load_index_reg);
                        ram_wr_data = a_load_byte_reg;
                    end
                end
                CMD_BEGIN:
                begin
                    read_phase_next = 1'b0;
                end
                CMD_START_SENT:
                begin
                    b_res_next.tx_valid = 1'b1;
                    b_res_next.tx_byte  = device_address_reg | {7'd0, read_phase_reg};
                end
                CMD_ADDR_SENT:
                begin
                    byte_index_next     = '0;
                    b_res_next.ack_ctrl = ACK_ENABLE;
                    if (!read_phase_reg)
                    begin
                        if (write_length_reg != '0)
                        begin
                            b_res_next.tx_valid    = 1'b1;
                            b_res_next.tx_from_ram = 1'b1;
                            ram_rd_en              = 1'b1;
                            ram_rd_addr            = '0;
                            byte_index_next        = 5'd1;
                        end
                    end
                    else if (read_length_reg == 5'd1)
                    begin
                        b_res_next.ack_ctrl = ACK_DISABLE;
                    end
                end
                CMD_BYTE_RECEIVED:
                begin
                    priority if (read_length_reg == 5'd1)
                    begin
                        b_res_next.stop_req = 1'b1;
                    end
                    else if (read_length_reg >= 5'd2 &&
                             byte_index_reg == read_length_reg - 5'd2)
                    begin
                        b_res_next.ack_ctrl = ACK_DISABLE;
                    end
                    else if (read_length_reg >= 5'd1 &&
                             byte_index_reg == read_length_reg - 5'd1)
                    begin
                        b_res_next.stop_req = 1'b1;
                    end
                    else
                    begin
                        // Middle byte or zero read length: no ACK or stop change
                        b_res_next.stop_req = 1'b0;
                    end
                    if (index_in_range)
                    begin
                        ram_wr_en           = 1'b1;
                        b_res_next.rx_valid = 1'b1;
                        b_res_next.rx_index = byte_index_reg[3:0];
                        b_res_next.rx_data  = a_rx_byte_reg;
                    end
                    byte_index_next = index_step;
                end
                CMD_TX_EMPTY:
                begin
                    priority if (byte_index_reg < write_length_reg)
                    begin
                        // Past the buffer end the byte is sent as zero
                        b_res_next.tx_valid    = 1'b1;
                        b_res_next.tx_from_ram = index_in_range;
                        ram_rd_en              = index_in_range;
                        byte_index_next        = index_step;
                    end
                    else if (!transfer_mode_reg)
                    begin
                        b_res_next.stop_req = 1'b1;
                    end
                    else
                    begin
                        read_phase_next      = 1'b1;
                        b_res_next.start_req = 1'b1;
                    end
                end
                default:
                begin
                    b_res_next = '0;
                end
            endcase
        end
    end

    // Sequencer state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_phase_reg <= 1'b0;
            byte_index_reg <= '0;
            b_valid_reg    <= 1'b0;
        end
        else
        begin
            read_phase_reg <= read_phase_next;
            byte_index_reg <= byte_index_next;
            if (a_move)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (a_move)
        begin
            b_res_reg <= b_res_next;
        end
    end

    i2c_seq_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_buffer (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Pack the result; buffer bytes come straight from the RAM read register
    assign tx_byte_out = b_res_reg.tx_from_ram ? ram_rd_data : b_res_reg.tx_byte;

    assign m_tdata = {6'd0,
                      b_res_reg.rx_data,
                      b_res_reg.rx_index,
                      b_res_reg.rx_valid,
                      b_res_reg.start_req,
                      b_res_reg.stop_req,
                      b_res_reg.ack_ctrl,
                      tx_byte_out,
                      b_res_reg.tx_valid};

endmodule
